>>> src/smbt_pkg.sv
package smbt_pkg;

  localparam int BUF_BYTES      = 8192;
  localparam int NUM_SLAVES     = 8;
  localparam int CTRL_REG_INDEX = 0;
  localparam int CS_REG_INDEX   = 1;
  localparam int XFER_REG_INDEX = 2;
  localparam int BUSY_BIT       = 31;

  localparam int NUM_REGS   = XFER_REG_INDEX + 1;
  localparam int BUF_BASE   = 8192;
  localparam int ADDR_W     = 14;
  localparam int REGNUM_W   = ADDR_W - 2;
  localparam int DATA_W     = 32;
  localparam int LANES      = DATA_W / 8;
  localparam int LANE_W     = $clog2(LANES);
  localparam int SLAVE_W    = 8;
  localparam int OFF_W      = $clog2(BUF_BYTES);
  localparam int LEN_W      = $clog2(BUF_BYTES + 1);
  localparam int BANK_DEPTH = BUF_BYTES / LANES;
  localparam int ROW_W      = $clog2(BANK_DEPTH);
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [SLAVE_W-1:0] SLAVE_LIMIT = SLAVE_W'((1 << NUM_SLAVES) - 1);

  typedef enum logic [1:0] {
    ACC_REG,
    ACC_BUF,
    ACC_GAP
  } acc_kind_t;

  typedef enum logic [1:0] {
    REG_CTRL,
    REG_CS,
    REG_XFER
  } reg_sel_t;

  // one classified bus access as it sits in the queue
  typedef struct packed {
    logic                          is_write;
    acc_kind_t                     kind;
    reg_sel_t                      reg_sel;
    logic                          fault;
    logic [DATA_W-1:0]             write_data;
    logic [8*SLAVE_W-1:0]          slave_bytes;
    logic [LANE_W-1:0]             off_lo;
    logic [LANES-1:0]              lane_en;
    logic [LANES-1:0]              bank_en;
    logic [LANES-1:0][ROW_W-1:0]   bank_row;
  } item_t;

endpackage

>>> src/smbt_ram.sv
module smbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> src/smbt_front.sv
module smbt_front (
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 func,
  input  logic [smbt_pkg::ADDR_W-1:0]          address,
  input  logic [smbt_pkg::DATA_W-1:0]          write_data,
  input  logic [2:0]                           access_bytes,
  input  logic [8*smbt_pkg::SLAVE_W-1:0]       slave_bytes,
  input  logic                                 clearing,
  input  logic                                 q_full,
  output logic                                 push,
  output smbt_pkg::item_t                      item
);

  logic [smbt_pkg::REGNUM_W-1:0] regnum;
  logic [smbt_pkg::ADDR_W-1:0]   off;
  logic [2:0]                    nb;
  logic                          is_reg;
  logic                          is_buf;
  logic [smbt_pkg::ADDR_W:0]     lane_sum [smbt_pkg::LANES];
  logic [smbt_pkg::LANES-1:0]    lane_en;

  assign in_stall = clearing || q_full;
  assign push     = in_valid && !in_stall;

  always_comb begin
    logic [smbt_pkg::LANE_W-1:0] lane;
    regnum = address[smbt_pkg::ADDR_W-1:2];
    off    = address - smbt_pkg::ADDR_W'(smbt_pkg::BUF_BASE);
    nb     = (access_bytes > 3'd4) ? 3'd4 : access_bytes;
    is_reg = regnum < smbt_pkg::REGNUM_W'(smbt_pkg::NUM_REGS);
    is_buf = address >= smbt_pkg::ADDR_W'(smbt_pkg::BUF_BASE);

    for (int i = 0; i < smbt_pkg::LANES; i++) begin
      lane_sum[i] = {1'b0, off} + (smbt_pkg::ADDR_W + 1)'(i);
      lane_en[i]  = is_buf && (3'(i) < nb) &&
                    (lane_sum[i] < (smbt_pkg::ADDR_W + 1)'(smbt_pkg::BUF_BYTES));
    end

    item             = '0;
    item.is_write    = func;
    item.write_data  = write_data;
    item.slave_bytes = slave_bytes;
    item.off_lo      = off[smbt_pkg::LANE_W-1:0];
    item.lane_en     = lane_en;
    item.fault       = is_reg && (access_bytes != 3'd4);
    item.reg_sel     = smbt_pkg::REG_CTRL;

    if (is_reg) begin
      item.kind = smbt_pkg::ACC_REG;
    end else if (is_buf) begin
      item.kind = smbt_pkg::ACC_BUF;
    end else begin
      item.kind = smbt_pkg::ACC_GAP;
    end

    if (regnum == smbt_pkg::REGNUM_W'(smbt_pkg::CS_REG_INDEX)) begin
      item.reg_sel = smbt_pkg::REG_CS;
    end else if (regnum == smbt_pkg::REGNUM_W'(smbt_pkg::XFER_REG_INDEX)) begin
      item.reg_sel = smbt_pkg::REG_XFER;
    end

    // bytes are interleaved over the banks: bank b holds the lane that lands on it
    for (int b = 0; b < smbt_pkg::LANES; b++) begin
      lane             = smbt_pkg::LANE_W'(b) - off[smbt_pkg::LANE_W-1:0];
      item.bank_en[b]  = lane_en[lane];
      item.bank_row[b] = lane_sum[lane][2 +: smbt_pkg::ROW_W];
    end
  end

endmodule

>>> src/smbt_queue.sv
module smbt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  smbt_pkg::item_t din,
  output logic            full,
  input  logic            pop,
  output smbt_pkg::item_t dout,
  output logic            empty
);

  smbt_pkg::item_t                entries [smbt_pkg::Q_DEPTH];
  logic [smbt_pkg::Q_PTR_W-1:0]  wr_ptr;
  logic [smbt_pkg::Q_PTR_W-1:0]  rd_ptr;
  logic [smbt_pkg::Q_CNT_W-1:0]  count;

  assign full  = count == smbt_pkg::Q_CNT_W'(smbt_pkg::Q_DEPTH);
  assign empty = count == '0;
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == smbt_pkg::Q_PTR_W'(smbt_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == smbt_pkg::Q_PTR_W'(smbt_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> src/smbt_back.sv
module smbt_back (
  input  logic                            clk,
  input  logic                            rst,
  input  smbt_pkg::item_t                 head,
  input  logic                            q_empty,
  output logic                            pop,
  output logic                            clearing,
  input  logic [smbt_pkg::SLAVE_W-1:0]    attached_slaves,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [smbt_pkg::DATA_W-1:0]     read_data,
  output logic                            fault,
  output logic [7:0]                      sent_byte,
  output logic                            sent_valid,
  output logic [smbt_pkg::SLAVE_W-1:0]    select_mask
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                          state;
  smbt_pkg::item_t                 cur;
  logic [smbt_pkg::DATA_W-1:0]     ctrl_reg;
  logic [smbt_pkg::DATA_W-1:0]     cs_reg;
  logic [smbt_pkg::DATA_W-1:0]     xfer_reg;
  logic                            loopback;
  logic [smbt_pkg::LEN_W-1:0]      xfer_len;
  logic [smbt_pkg::LEN_W-1:0]      done;
  logic [smbt_pkg::ROW_W-1:0]      clr_row;

  logic                            ram_we    [smbt_pkg::LANES];
  logic [smbt_pkg::ROW_W-1:0]      ram_waddr [smbt_pkg::LANES];
  logic [7:0]                      ram_wdata [smbt_pkg::LANES];
  logic [7:0]                      ram_rd_a  [smbt_pkg::LANES];
  logic [7:0]                      ram_rd_b  [smbt_pkg::LANES];

  logic [smbt_pkg::LANE_W-1:0]     pos_bank;
  logic [smbt_pkg::ROW_W-1:0]      pos_row;
  logic                            out_free;
  logic                            fire;
  logic                            pending;
  logic [7:0]                      old_byte;
  logic [7:0]                      new_byte;
  logic [smbt_pkg::SLAVE_W-1:0]    sel;
  logic [7:0]                      reply;
  logic [smbt_pkg::LEN_W-1:0]      done_next;
  logic                            busy;
  logic [smbt_pkg::DATA_W-1:0]     xfer_read;
  logic [smbt_pkg::DATA_W-1:0]     buf_read;
  logic [smbt_pkg::DATA_W-1:0]     rdata;
  logic [smbt_pkg::LEN_W-1:0]      len_clamped;

  assign pos_bank = done[smbt_pkg::LANE_W-1:0];
  assign pos_row  = done[smbt_pkg::LANE_W +: smbt_pkg::ROW_W];
  assign clearing = state == S_CLEAR;
  assign pop      = (state == S_IDLE) && !q_empty;
  assign out_free = !out_valid || !out_stall;
  assign fire     = (state == S_EXEC) && out_free;

  // four byte banks, so any four consecutive bytes hit distinct banks
  for (genvar b = 0; b < smbt_pkg::LANES; b++) begin : g_bank
    smbt_ram #(
      .WIDTH(8),
      .DEPTH(smbt_pkg::BANK_DEPTH)
    ) u_ram (
      .clk    (clk),
      .we     (ram_we[b]),
      .waddr  (ram_waddr[b]),
      .wdata  (ram_wdata[b]),
      .re     (pop),
      .raddr_a(head.bank_row[b]),
      .raddr_b(pos_row),
      .rdata_a(ram_rd_a[b]),
      .rdata_b(ram_rd_b[b])
    );
  end

  always_comb begin
    logic [smbt_pkg::LANE_W-1:0] bank;
    logic [smbt_pkg::LANE_W-1:0] lane;
    logic [7:0]                  byte_val;

    pending  = !cur.is_write && (done < xfer_len);
    old_byte = ram_rd_b[pos_bank];
    sel      = cs_reg[smbt_pkg::SLAVE_W-1:0] & attached_slaves & smbt_pkg::SLAVE_LIMIT;
    reply    = '0;
    for (int m = 0; m < smbt_pkg::SLAVE_W; m++) begin
      if (sel[m]) begin
        reply = reply | cur.slave_bytes[8*m +: 8];
      end
    end
    new_byte  = loopback ? ~old_byte : reply;
    done_next = pending ? smbt_pkg::LEN_W'(done + 1'b1) : done;
    busy      = done_next != xfer_len;
    xfer_read = xfer_reg;
    xfer_read[smbt_pkg::BUSY_BIT] = busy;

    // buffer bytes see the byte just moved by this same read
    buf_read = '0;
    for (int i = 0; i < smbt_pkg::LANES; i++) begin
      bank     = cur.off_lo + smbt_pkg::LANE_W'(i);
      byte_val = ram_rd_a[bank];
      if (pending && (bank == pos_bank) && (cur.bank_row[bank] == pos_row)) begin
        byte_val = new_byte;
      end
      if (cur.lane_en[i]) begin
        buf_read[8*i +: 8] = byte_val;
      end
    end

    rdata = '0;
    if (!cur.is_write) begin
      case (cur.kind)
        smbt_pkg::ACC_REG: begin
          if (!cur.fault) begin
            case (cur.reg_sel)
              smbt_pkg::REG_CTRL: rdata = ctrl_reg;
              smbt_pkg::REG_CS:   rdata = cs_reg;
              smbt_pkg::REG_XFER: rdata = xfer_read;
              default:            rdata = '0;
            endcase
          end
        end
        smbt_pkg::ACC_BUF: rdata = buf_read;
        default:           rdata = '0;
      endcase
    end

    len_clamped = (cur.write_data[15:0] > 16'(smbt_pkg::BUF_BYTES)) ?
                  smbt_pkg::LEN_W'(smbt_pkg::BUF_BYTES) :
                  smbt_pkg::LEN_W'(cur.write_data[15:0]);

    for (int b = 0; b < smbt_pkg::LANES; b++) begin
      lane         = smbt_pkg::LANE_W'(b) - cur.off_lo;
      ram_we[b]    = 1'b0;
      ram_waddr[b] = cur.bank_row[b];
      ram_wdata[b] = cur.write_data[8*lane +: 8];
      if (state == S_CLEAR) begin
        ram_we[b]    = 1'b1;
        ram_waddr[b] = clr_row;
        ram_wdata[b] = '0;
      end else if (fire && cur.is_write && (cur.kind == smbt_pkg::ACC_BUF)) begin
        ram_we[b] = cur.bank_en[b];
      end else if (fire && pending && (pos_bank == smbt_pkg::LANE_W'(b))) begin
        ram_we[b]    = 1'b1;
        ram_waddr[b] = pos_row;
        ram_wdata[b] = new_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      ctrl_reg  <= '0;
      cs_reg    <= '0;
      xfer_reg  <= '0;
      loopback  <= 1'b0;
      xfer_len  <= '0;
      done      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == smbt_pkg::ROW_W'(smbt_pkg::BANK_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            cur   <= head;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state       <= S_IDLE;
            read_data   <= rdata;
            fault       <= cur.fault;
            sent_valid  <= pending && !loopback;
            sent_byte   <= (pending && !loopback) ? old_byte : '0;
            select_mask <= (pending && !loopback) ? sel : '0;
            if (cur.is_write) begin
              if ((cur.kind == smbt_pkg::ACC_REG) && !cur.fault) begin
                case (cur.reg_sel)
                  smbt_pkg::REG_CTRL: ctrl_reg <= cur.write_data;
                  smbt_pkg::REG_CS:   cs_reg   <= cur.write_data;
                  smbt_pkg::REG_XFER: begin
                    xfer_reg <= cur.write_data;
                    xfer_len <= len_clamped;
                    loopback <= ctrl_reg[0];
                    done     <= '0;
                  end
                  default: ;
                endcase
              end
            end else begin
              done <= done_next;
              xfer_reg[smbt_pkg::BUSY_BIT] <= busy;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done <= xfer_len)
    else $error("byte count ran past transfer length");

  assert property (@(posedge clk) disable iff (rst)
    xfer_len <= smbt_pkg::LEN_W'(smbt_pkg::BUF_BYTES))
    else $error("transfer length above buffer size");

  assert property (@(posedge clk) disable iff (rst) (state == S_CLEAR) |-> !pop)
    else $error("item taken during buffer clear");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !sent_valid) |-> (sent_byte == '0 && select_mask == '0))
    else $error("exchange fields set without an exchange");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_data) && $stable(fault)))
    else $error("result overwritten while stalled");

endmodule

>>> src/spi_master_buffered_transfer.sv
// SPI master with a byte transfer buffer, seen as bus accesses.
//
// Input channel (in_valid / in_stall): one bus access per item: func,
// address, write_data, access_bytes and the slaves' reply bytes. Output
// channel (out_valid / out_stall): exactly one result item per access, in
// order: read_data, fault, and the exchange fields sent_byte, sent_valid,
// select_mask. cfg_we / cfg_wdata write the attached-slaves mask (reset 255).
//
// Accepted items go into a two-entry queue; the back end takes one item at a
// time and finishes it before popping the next: in S_IDLE, as it pops the
// item, it reads the four buffer banks (the pending transfer byte and the
// accessed bytes together); in S_EXEC, once the output is free, it writes
// back the moved byte and registers the result.
//
// After reset the buffer is cleared, one row of four bytes a cycle:
// BUF_BYTES/4 = 2048 rows, during which in_stall is high. When out_stall is
// held the result stays put, the back end waits, and the queue keeps taking
// items until it is full.
module spi_master_buffered_transfer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [smbt_pkg::SLAVE_W-1:0]       cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               func,
  input  logic [smbt_pkg::ADDR_W-1:0]        address,
  input  logic [smbt_pkg::DATA_W-1:0]        write_data,
  input  logic [2:0]                         access_bytes,
  input  logic [8*smbt_pkg::SLAVE_W-1:0]     slave_bytes,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [smbt_pkg::DATA_W-1:0]        read_data,
  output logic                               fault,
  output logic [7:0]                         sent_byte,
  output logic                               sent_valid,
  output logic [smbt_pkg::SLAVE_W-1:0]       select_mask
);

  logic [smbt_pkg::SLAVE_W-1:0] attached_slaves;
  logic                         clearing;
  logic                         q_full;
  logic                         q_empty;
  logic                         push;
  logic                         pop;
  smbt_pkg::item_t              front_item;
  smbt_pkg::item_t              head;

  always_ff @(posedge clk) begin
    if (rst) begin
      attached_slaves <= '1;
    end else if (cfg_we) begin
      attached_slaves <= cfg_wdata;
    end
  end

  smbt_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .address     (address),
    .write_data  (write_data),
    .access_bytes(access_bytes),
    .slave_bytes (slave_bytes),
    .clearing    (clearing),
    .q_full      (q_full),
    .push        (push),
    .item        (front_item)
  );

  smbt_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (front_item),
    .full (q_full),
    .pop  (pop),
    .dout (head),
    .empty(q_empty)
  );

  smbt_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .q_empty        (q_empty),
    .pop            (pop),
    .clearing       (clearing),
    .attached_slaves(attached_slaves),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_data      (read_data),
    .fault          (fault),
    .sent_byte      (sent_byte),
    .sent_valid     (sent_valid),
    .select_mask    (select_mask)
  );

endmodule
